// ===== design/mmx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the min/max extract store.
// Used by mmx_cell, mmx_rsp_queue, minmax_extract_store and the testbench; depends on nothing.
package mmx_pkg;

   localparam int CAPACITY = 256;
   localparam int VAL_W    = 20;
   localparam int TOTAL_W  = 63;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_CLOSE  = 1'b1
   } mode_type;

   typedef struct packed {
      logic               mode;
      logic [VAL_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VAL_W-1:0]   max_value;
      logic [VAL_W-1:0]   min_value;
      logic [VAL_W-1:0]   difference;
      logic [TOTAL_W-1:0] running_total;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic               insert;
      logic               close;
      logic [VAL_W-1:0]   value;
   } cell_cmd_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic               valid;
      logic               lo_keep;
      logic               hi_keep;
      logic [VAL_W-1:0]   lo;
      logic [VAL_W-1:0]   hi;
   } cell_link_type;

   // Left of cell 0: always valid and keeping, so a new value lands in cell 0.
   localparam cell_link_type LINK_LEFT_EDGE =
      '{valid: 1'b1, lo_keep: 1'b1, hi_keep: 1'b1, lo: '0, hi: '0};
   // Right of the last cell: empty.
   localparam cell_link_type LINK_RIGHT_EDGE =
      '{valid: 1'b0, lo_keep: 1'b0, hi_keep: 1'b0, lo: '0, hi: '0};

endpackage

// ===== design/mmx_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted row: holds the i-th smallest and the i-th largest value.
// Depends on mmx_pkg.
module mmx_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mmx_pkg::cell_cmd_type cmd,
   input  mmx_pkg::cell_link_type left,
   input  mmx_pkg::cell_link_type right1,
   input  mmx_pkg::cell_link_type right2,
   output mmx_pkg::cell_link_type self
);
   import mmx_pkg::*;

   logic             valid_ff, valid_in;
   logic [VAL_W-1:0] lo_ff, lo_in;
   logic [VAL_W-1:0] hi_ff, hi_in;
   logic             lo_keep, hi_keep;

   // The ascending copy treats an empty cell as plus infinity, the descending
   // copy as minus infinity, so an empty cell never keeps its contents.
   assign lo_keep = valid_ff && (lo_ff <= cmd.value);
   assign hi_keep = valid_ff && (hi_ff >= cmd.value);

   always_comb begin
      valid_in = valid_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (cmd.insert) begin
         valid_in = valid_ff | left.valid;
         lo_in    = lo_keep ? lo_ff : (left.lo_keep ? cmd.value : left.lo);
         hi_in    = hi_keep ? hi_ff : (left.hi_keep ? cmd.value : left.hi);
      end else if (cmd.close) begin
         // Minimum leaves at the head; the maximum drops off the tail,
         // so the occupied length shrinks by two.
         valid_in = right2.valid;
         lo_in    = right1.lo;
         hi_in    = right1.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign self = '{valid: valid_ff, lo_keep: lo_keep, hi_keep: hi_keep,
                   lo: lo_ff, hi: hi_ff};

endmodule

// ===== design/mmx_rsp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry result queue between the cell row and the result channel.
// Depends on mmx_pkg.
module mmx_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mmx_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmx_pkg::rsp_type rsp_payload
);
   import mmx_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/minmax_extract_store.sv =====
`timescale 1ns / 1ps
// Min/max extract store: a row of CAPACITY sorted cells; cell 0 holds min and max.
// The result of an item is registered in the result queue and offered on rsp behind any earlier results.
// Throughput: one item per cycle while the result queue is not full; every cell shifts or inserts at the transfer.
// A two-entry result queue lets req keep transferring while one result waits.
// Reset clears the cell valid bits, the running total and the result queue;
// no clearing pass is needed, the block takes items in the first cycle after reset.
module minmax_extract_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmx_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmx_pkg::rsp_type rsp_payload
);
   import mmx_pkg::*;

   cell_link_type      links [CAPACITY];
   cell_cmd_type       cmd;
   rsp_type            result;
   logic               queue_full;
   logic               req_go;
   logic               store_full;
   logic               enough;
   logic               insert_go;
   logic               close_go;
   logic [VAL_W-1:0]   diff;
   logic [TOTAL_W-1:0] total_ff, total_in;

   assign req_ready  = !queue_full;
   assign req_go     = req_valid && req_ready;
   assign store_full = links[CAPACITY-1].valid;
   assign enough     = links[1].valid;
   assign insert_go  = req_go && (req_payload.mode == MODE_INSERT) && !store_full;
   assign close_go   = req_go && (req_payload.mode == MODE_CLOSE) && enough;

   assign cmd = '{insert: insert_go, close: close_go, value: req_payload.value};

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         cell_link_type left_link, right1_link, right2_link;
         if (i == 0) begin : g_left_edge
            assign left_link = LINK_LEFT_EDGE;
         end else begin : g_left
            assign left_link = links[i-1];
         end
         if (i + 1 < CAPACITY) begin : g_right1
            assign right1_link = links[i+1];
         end else begin : g_right1_edge
            assign right1_link = LINK_RIGHT_EDGE;
         end
         if (i + 2 < CAPACITY) begin : g_right2
            assign right2_link = links[i+2];
         end else begin : g_right2_edge
            assign right2_link = LINK_RIGHT_EDGE;
         end
         mmx_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .cmd    (cmd),
            .left   (left_link),
            .right1 (right1_link),
            .right2 (right2_link),
            .self   (links[i])
         );
      end
   endgenerate

   assign diff     = links[0].hi - links[0].lo;
   assign total_in = close_go ? total_ff + {{(TOTAL_W-VAL_W){1'b0}}, diff} : total_ff;

   always_comb begin
      result = '{status: ST_OK, max_value: '0, min_value: '0, difference: '0,
                 running_total: total_in};
      if (req_payload.mode == MODE_INSERT) begin
         if (store_full) begin
            result.status = ST_FULL;
         end
      end else if (enough) begin
         result.max_value  = links[0].hi;
         result.min_value  = links[0].lo;
         result.difference = diff;
      end else begin
         result.status = ST_SHORT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   mmx_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (req_go),
      .push_data   (result),
      .full        (queue_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // Occupied cells start at cell 0: cell 1 is never occupied while cell 0 is empty.
   assert property (@(posedge clock) disable iff (reset)
      links[1].valid |-> links[0].valid)
      else $error("cell row has a gap at its head");

   // Head cell ordering: min not above the next smallest, max not below the next largest, min not above max.
   assert property (@(posedge clock) disable iff (reset)
      links[1].valid |-> (links[0].lo <= links[1].lo) && (links[0].hi >= links[1].hi)
                         && (links[0].lo <= links[0].hi))
      else $error("cell row lost its sort order");

   // The total moves only on a successful close.
   assert property (@(posedge clock) disable iff (reset)
      !close_go |=> $stable(total_ff))
      else $error("running total changed without a close");

   // A reported round is consistent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.max_value >= rsp_payload.min_value)
                    && (rsp_payload.difference
                        == rsp_payload.max_value - rsp_payload.min_value))
      else $error("result max, min and difference disagree");
`endif

endmodule

// ===== tb/minmax_extract_store_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for minmax_extract_store: directed and random insert/close items.
// Depends on mmx_pkg and the minmax_extract_store design with its mmx_cell and mmx_rsp_queue.
module minmax_extract_store_test;
   import mmx_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   minmax_extract_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   req_type     pending_items[$];
   rsp_type     expected_results[$];
   logic        req_done = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   // Shadow copy of the store: each inserted value sits in the lowest free slot.
   logic [VAL_W-1:0]   held_value [CAPACITY];
   logic               held_used [CAPACITY] = '{default: 1'b0};
   int unsigned        held_count = 0;
   logic [TOTAL_W-1:0] total_model = '0;

   function automatic rsp_type store_step(req_type item);
      rsp_type outcome;
      int      hi;
      int      lo;
      outcome = '0;
      hi = -1;
      lo = -1;
      if (item.mode == MODE_INSERT) begin
         if (held_count >= CAPACITY) begin
            outcome.status = ST_FULL;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (!held_used[i] && hi < 0) begin
                  hi = i;
               end
            end
            held_value[hi] = item.value;
            held_used[hi] = 1'b1;
            held_count++;
            outcome.status = ST_OK;
         end
      end else if (held_count < 2) begin
         outcome.status = ST_SHORT;
      end else begin
         // The maximum comes from its lowest slot; the minimum from the lowest other slot.
         for (int i = 0; i < CAPACITY; i++) begin
            if (held_used[i] && (hi < 0 || held_value[i] > held_value[hi])) begin
               hi = i;
            end
         end
         for (int i = 0; i < CAPACITY; i++) begin
            if (held_used[i] && i != hi && (lo < 0 || held_value[i] < held_value[lo])) begin
               lo = i;
            end
         end
         outcome.status = ST_OK;
         outcome.max_value = held_value[hi];
         outcome.min_value = held_value[lo];
         outcome.difference = held_value[hi] - held_value[lo];
         held_used[hi] = 1'b0;
         held_used[lo] = 1'b0;
         held_count -= 2;
         total_model = total_model + TOTAL_W'(outcome.difference);
      end
      outcome.running_total = total_model;
      return outcome;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Extremes and a narrow range show up often so that duplicates are common.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return VAL_W'($urandom_range(15));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic add_item(mode_type mode, logic [VAL_W-1:0] value);
      req_type item;
      item.mode = mode;
      item.value = value;
      pending_items.push_back(item);
   endtask

   task automatic queue_random_chunk(int count, int insert_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < insert_pct) begin
            add_item(MODE_INSERT, pick_value());
         end else begin
            add_item(MODE_CLOSE, VAL_W'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // Sender and receiver. A new item is offered only after the previous transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_done) begin
            req_done = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (req_valid && req_ready) begin
            expected_results.push_back(store_step(req_payload));
            req_done = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no expected result waiting");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_payload.status));
               compare_field("max_value", 64'(want.max_value),
                             64'(rsp_payload.max_value));
               compare_field("min_value", 64'(want.min_value),
                             64'(rsp_payload.min_value));
               compare_field("difference", 64'(want.difference),
                             64'(rsp_payload.difference));
               compare_field("running_total", 64'(want.running_total),
                             64'(rsp_payload.running_total));
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("minmax_extract_store_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 65;

      // Directed: short closes, widest difference, duplicates, ignored close value.
      add_item(MODE_CLOSE, '0);
      add_item(MODE_INSERT, 20'h12345);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_INSERT, '0);
      add_item(MODE_INSERT, '1);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_INSERT, 20'h12345);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_INSERT, 20'h7);
      add_item(MODE_INSERT, 20'h7);
      add_item(MODE_INSERT, 20'h7);
      add_item(MODE_INSERT, 20'h3);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_CLOSE, '0);
      add_item(MODE_INSERT, 20'hAAAAA);
      add_item(MODE_INSERT, 20'h55555);
      add_item(MODE_CLOSE, '1);
      add_item(MODE_CLOSE, '1);
      add_item(MODE_INSERT, '1);
      add_item(MODE_CLOSE, 20'h5A5A5);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < 14; chunk++) begin
            case ($urandom_range(4))
               0: queue_random_chunk(30, 25);
               1: queue_random_chunk(30, 50);
               2: queue_random_chunk(30, 65);
               3: queue_random_chunk(30, 80);
               default: queue_random_chunk(30, 95);
            endcase
         end
         // Overfill the store so that several inserts are dropped, then drain it.
         if (phase == 1) begin
            queue_random_chunk(262, 100);
            queue_random_chunk(130, 0);
         end
         // The test waits here until every item is sent and every expected result has transferred.
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("minmax_extract_store_test: done, clean");
      end else begin
         $display("minmax_extract_store_test: done, errors");
      end
      $finish;
   end

endmodule
